/* rtl/rv32de_pkg.sv */
// types, opcode and function codes shared by the rv32i decode and execute block
package rv32de_pkg;

   localparam int XLEN = 32;

   // major opcodes
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_OP     = 7'b0110011;

   // funct7 codes
   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   // funct3 codes, arithmetic
   localparam logic [2:0] F3_ADD  = 3'b000;
   localparam logic [2:0] F3_SLL  = 3'b001;
   localparam logic [2:0] F3_SLT  = 3'b010;
   localparam logic [2:0] F3_SLTU = 3'b011;
   localparam logic [2:0] F3_XOR  = 3'b100;
   localparam logic [2:0] F3_SR   = 3'b101;
   localparam logic [2:0] F3_OR   = 3'b110;
   localparam logic [2:0] F3_AND  = 3'b111;

   // funct3 codes, branches
   localparam logic [2:0] F3_BEQ  = 3'b000;
   localparam logic [2:0] F3_BNE  = 3'b001;
   localparam logic [2:0] F3_BLT  = 3'b100;
   localparam logic [2:0] F3_BGE  = 3'b101;
   localparam logic [2:0] F3_BLTU = 3'b110;
   localparam logic [2:0] F3_BGEU = 3'b111;

   // funct3 codes, loads and stores
   localparam logic [2:0] F3_LB  = 3'b000;
   localparam logic [2:0] F3_LH  = 3'b001;
   localparam logic [2:0] F3_LW  = 3'b010;
   localparam logic [2:0] F3_LBU = 3'b100;
   localparam logic [2:0] F3_LHU = 3'b101;
   localparam logic [2:0] F3_SB  = 3'b000;
   localparam logic [2:0] F3_SH  = 3'b001;
   localparam logic [2:0] F3_SW  = 3'b010;

   localparam logic [2:0] F3_JALR = 3'b000;

   // result kind
   typedef enum logic [1:0] {
      KIND_REG    = 2'd0,
      KIND_LOAD   = 2'd1,
      KIND_STORE  = 2'd2,
      KIND_BRANCH = 2'd3
   } kind_type;

   // memory access size
   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_HALF = 2'd1,
      SIZE_WORD = 2'd2
   } size_type;

   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU,
      ALU_XOR, ALU_SRL, ALU_SRA, ALU_OR, ALU_AND
   } alu_op_type;

   typedef enum logic [2:0] {
      RES_NONE, RES_ALU, RES_UIMM, RES_AUIPC, RES_LINK
   } res_sel_type;

   typedef enum logic [1:0] {
      TGT_NONE, TGT_PC_IMM, TGT_RS1_IMM, TGT_JALR
   } tgt_sel_type;

   typedef enum logic [2:0] {
      BR_NEVER, BR_ALWAYS, BR_EQ, BR_NE, BR_LT, BR_GE, BR_LTU, BR_GEU
   } br_cond_type;

   // control word from decode to execute
   typedef struct packed {
      logic             illegal;
      kind_type         kind;
      logic [4:0]       rd_index;
      logic             writes_rd;
      res_sel_type      res_sel;
      alu_op_type       alu_op;
      logic             use_imm;
      logic [XLEN-1:0]  imm;
      tgt_sel_type      tgt_sel;
      br_cond_type      br_cond;
      size_type         access_size;
      logic             load_unsigned;
      logic             store_en;
   } dec_type;

   localparam dec_type DEC_NONE = '{
      illegal:       1'b0,
      kind:          KIND_REG,
      rd_index:      5'd0,
      writes_rd:     1'b0,
      res_sel:       RES_NONE,
      alu_op:        ALU_ADD,
      use_imm:       1'b0,
      imm:           '0,
      tgt_sel:       TGT_NONE,
      br_cond:       BR_NEVER,
      access_size:   SIZE_BYTE,
      load_unsigned: 1'b0,
      store_en:      1'b0
   };

   // one result beat
   typedef struct packed {
      logic             illegal;
      kind_type         kind;
      logic [4:0]       rd_index;
      logic             writes_rd;
      logic [XLEN-1:0]  result_value;
      logic [XLEN-1:0]  target_or_address;
      logic             taken;
      size_type         access_size;
      logic             load_unsigned;
      logic [XLEN-1:0]  store_data;
   } rsp_type;

endpackage

/* rtl/rv32de_req_if.sv */
// request channel: instruction word, pc and both source operands
interface rv32de_req_if import rv32de_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [XLEN-1:0] instruction;
   logic [XLEN-1:0] pc;
   logic [XLEN-1:0] rs1_value;
   logic [XLEN-1:0] rs2_value;

   modport source (output valid, instruction, pc, rs1_value, rs2_value, input ready);
   modport sink   (input valid, instruction, pc, rs1_value, rs2_value, output ready);
endinterface

/* rtl/rv32de_rsp_if.sv */
// response channel: decoded and executed instruction result
interface rv32de_rsp_if import rv32de_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            illegal;
   logic [1:0]      kind;
   logic [4:0]      rd_index;
   logic            writes_rd;
   logic [XLEN-1:0] result_value;
   logic [XLEN-1:0] target_or_address;
   logic            taken;
   logic [1:0]      access_size;
   logic            load_unsigned;
   logic [XLEN-1:0] store_data;

   modport source (output valid, illegal, kind, rd_index, writes_rd, result_value,
                   target_or_address, taken, access_size, load_unsigned, store_data,
                   input ready);
   modport sink   (input valid, illegal, kind, rd_index, writes_rd, result_value,
                   target_or_address, taken, access_size, load_unsigned, store_data,
                   output ready);
endinterface

/* rtl/rv32i_decode_execute.sv */
// top level of the rv32i decode and execute stage
//
//   channel  | direction | beat contents
//   ---------+-----------+-----------------------------------------------------
//   req_ch   | in        | instruction, pc, rs1_value, rs2_value
//   rsp_ch   | out       | illegal, kind, rd_index, writes_rd, result_value,
//            |           | target_or_address, taken, access_size, load_unsigned,
//            |           | store_data
//
// one beat per cycle unless rsp_ch stalls; path: input register, then result register
// decode and execute sit in one combinational pass between those two registers
// synchronous reset clears both stage valid flags; payload registers are not reset
// a stalled result holds in the result register while the input register can still
// take a beat; req_ch.ready falls only when both stages are full and rsp_ch stalls
module rv32i_decode_execute import rv32de_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rv32de_req_if.sink    req_ch,
   rv32de_rsp_if.source  rsp_ch
);

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [XLEN-1:0] instr_ff;
   logic [XLEN-1:0] instr_in;
   logic [XLEN-1:0] pc_ff;
   logic [XLEN-1:0] pc_in;
   logic [XLEN-1:0] rs1_ff;
   logic [XLEN-1:0] rs1_in;
   logic [XLEN-1:0] rs2_ff;
   logic [XLEN-1:0] rs2_in;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_type         out_ff;
   rsp_type         out_in;

   logic            out_room;
   logic            in_room;
   logic            req_take;
   logic            out_load;
   dec_type         dec;
   rsp_type         exec_rsp;

   // decode and execute
   rv32de_decode u_decode (
      .instruction (instr_ff),
      .dec         (dec)
   );

   rv32de_execute u_execute (
      .dec       (dec),
      .pc        (pc_ff),
      .rs1_value (rs1_ff),
      .rs2_value (rs2_ff),
      .rsp       (exec_rsp)
   );

   // stage handshake
   always_comb begin
      out_room     = !out_valid_ff || rsp_ch.ready;
      in_room      = !in_valid_ff || out_room;
      req_take     = req_ch.valid && in_room;
      out_load     = in_valid_ff && out_room;

      in_valid_in  = req_take || (in_valid_ff && !out_room);
      instr_in     = req_take ? req_ch.instruction : instr_ff;
      pc_in        = req_take ? req_ch.pc : pc_ff;
      rs1_in       = req_take ? req_ch.rs1_value : rs1_ff;
      rs2_in       = req_take ? req_ch.rs2_value : rs2_ff;

      out_valid_in = out_load || (out_valid_ff && !rsp_ch.ready);
      out_in       = out_load ? exec_rsp : out_ff;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      instr_ff <= instr_in;
      pc_ff    <= pc_in;
      rs1_ff   <= rs1_in;
      rs2_ff   <= rs2_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   // ports
   assign req_ch.ready             = in_room;
   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.illegal           = out_ff.illegal;
   assign rsp_ch.kind              = out_ff.kind;
   assign rsp_ch.rd_index          = out_ff.rd_index;
   assign rsp_ch.writes_rd         = out_ff.writes_rd;
   assign rsp_ch.result_value      = out_ff.result_value;
   assign rsp_ch.target_or_address = out_ff.target_or_address;
   assign rsp_ch.taken             = out_ff.taken;
   assign rsp_ch.access_size       = out_ff.access_size;
   assign rsp_ch.load_unsigned     = out_ff.load_unsigned;
   assign rsp_ch.store_data        = out_ff.store_data;

`ifndef ASSERT_OFF
   // an illegal beat carries nothing but the flag
   a_illegal_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.illegal) |-> (rsp_ch.kind == KIND_REG && !rsp_ch.writes_rd
         && rsp_ch.result_value == '0 && rsp_ch.target_or_address == '0
         && !rsp_ch.taken && rsp_ch.store_data == '0))
      else $error("illegal beat carries payload");

   // only branches and jumps may be taken
   a_taken_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.taken) |-> (rsp_ch.kind == KIND_BRANCH))
      else $error("taken set on non-branch beat");

   // a beat that does not write a register carries rd_index zero
   a_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.writes_rd) |-> (rsp_ch.rd_index == 5'd0))
      else $error("rd_index set without writes_rd");

   // a held input beat is not lost while the result stage is stalled
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ch.ready) |=> (in_valid_ff && $stable(instr_ff)))
      else $error("input beat dropped under stall");

   // an accepted request reaches the input register
   a_in_load: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> in_valid_ff)
      else $error("accepted beat not registered");
`endif

endmodule

/* rtl/rv32de_decode.sv */
// instruction decoder: opcode and function fields to a control word with immediate
module rv32de_decode import rv32de_pkg::*; (
   input  logic [XLEN-1:0] instruction,
   output dec_type         dec
);

   logic [6:0]      opc;
   logic [2:0]      f3;
   logic [6:0]      f7;
   logic [XLEN-1:0] imm_i;
   logic [XLEN-1:0] imm_s;
   logic [XLEN-1:0] imm_b;
   logic [XLEN-1:0] imm_u;
   logic [XLEN-1:0] imm_j;
   logic            ill;

   // field extraction and immediate formats
   always_comb begin
      opc   = instruction[6:0];
      f3    = instruction[14:12];
      f7    = instruction[31:25];
      imm_i = {{20{instruction[31]}}, instruction[31:20]};
      imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
      imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
               instruction[30:25], instruction[11:8], 1'b0};
      imm_u = {instruction[31:12], 12'd0};
      imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
               instruction[20], instruction[30:21], 1'b0};
   end

   // control word per opcode
   always_comb begin
      dec          = DEC_NONE;
      dec.rd_index = instruction[11:7];
      ill          = 1'b0;
      case (opc)
         OPC_LUI: begin
            dec.writes_rd = 1'b1;
            dec.res_sel   = RES_UIMM;
            dec.imm       = imm_u;
         end
         OPC_AUIPC: begin
            dec.writes_rd = 1'b1;
            dec.res_sel   = RES_AUIPC;
            dec.imm       = imm_u;
         end
         OPC_JAL: begin
            dec.kind      = KIND_BRANCH;
            dec.writes_rd = 1'b1;
            dec.res_sel   = RES_LINK;
            dec.imm       = imm_j;
            dec.tgt_sel   = TGT_PC_IMM;
            dec.br_cond   = BR_ALWAYS;
         end
         OPC_JALR: begin
            ill           = (f3 != F3_JALR);
            dec.kind      = KIND_BRANCH;
            dec.writes_rd = 1'b1;
            dec.res_sel   = RES_LINK;
            dec.imm       = imm_i;
            dec.tgt_sel   = TGT_JALR;
            dec.br_cond   = BR_ALWAYS;
         end
         OPC_BRANCH: begin
            dec.kind    = KIND_BRANCH;
            dec.imm     = imm_b;
            dec.tgt_sel = TGT_PC_IMM;
            case (f3)
               F3_BEQ:  dec.br_cond = BR_EQ;
               F3_BNE:  dec.br_cond = BR_NE;
               F3_BLT:  dec.br_cond = BR_LT;
               F3_BGE:  dec.br_cond = BR_GE;
               F3_BLTU: dec.br_cond = BR_LTU;
               F3_BGEU: dec.br_cond = BR_GEU;
               default: ill = 1'b1;
            endcase
         end
         OPC_LOAD: begin
            dec.kind          = KIND_LOAD;
            dec.writes_rd     = 1'b1;
            dec.imm           = imm_i;
            dec.tgt_sel       = TGT_RS1_IMM;
            dec.load_unsigned = f3[2];
            case (f3)
               F3_LB, F3_LBU: dec.access_size = SIZE_BYTE;
               F3_LH, F3_LHU: dec.access_size = SIZE_HALF;
               F3_LW:         dec.access_size = SIZE_WORD;
               default:       ill = 1'b1;
            endcase
         end
         OPC_STORE: begin
            dec.kind     = KIND_STORE;
            dec.imm      = imm_s;
            dec.tgt_sel  = TGT_RS1_IMM;
            dec.store_en = 1'b1;
            case (f3)
               F3_SB:   dec.access_size = SIZE_BYTE;
               F3_SH:   dec.access_size = SIZE_HALF;
               F3_SW:   dec.access_size = SIZE_WORD;
               default: ill = 1'b1;
            endcase
         end
         OPC_OPIMM, OPC_OP: begin
            dec.writes_rd = 1'b1;
            dec.res_sel   = RES_ALU;
            dec.use_imm   = (opc == OPC_OPIMM);
            dec.imm       = imm_i;
            case (f3)
               F3_ADD: begin
                  if (opc == OPC_OP && f7 == F7_ALT) begin
                     dec.alu_op = ALU_SUB;
                  end else begin
                     dec.alu_op = ALU_ADD;
                  end
                  ill = (opc == OPC_OP) && (f7 != F7_BASE) && (f7 != F7_ALT);
               end
               F3_SLL: begin
                  dec.alu_op = ALU_SLL;
                  ill        = (f7 != F7_BASE);
               end
               F3_SR: begin
                  dec.alu_op = (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
                  ill        = (f7 != F7_BASE) && (f7 != F7_ALT);
               end
               F3_SLT: begin
                  dec.alu_op = ALU_SLT;
                  ill        = (opc == OPC_OP) && (f7 != F7_BASE);
               end
               F3_SLTU: begin
                  dec.alu_op = ALU_SLTU;
                  ill        = (opc == OPC_OP) && (f7 != F7_BASE);
               end
               F3_XOR: begin
                  dec.alu_op = ALU_XOR;
                  ill        = (opc == OPC_OP) && (f7 != F7_BASE);
               end
               F3_OR: begin
                  dec.alu_op = ALU_OR;
                  ill        = (opc == OPC_OP) && (f7 != F7_BASE);
               end
               F3_AND: begin
                  dec.alu_op = ALU_AND;
                  ill        = (opc == OPC_OP) && (f7 != F7_BASE);
               end
               default: ill = 1'b1;
            endcase
         end
         default: ill = 1'b1;
      endcase

      // unsupported encoding clears everything but the flag
      if (ill) begin
         dec         = DEC_NONE;
         dec.illegal = 1'b1;
      end
   end

endmodule

/* rtl/rv32de_execute.sv */
// execute: alu, adders for targets and addresses, branch compare and result packing
module rv32de_execute import rv32de_pkg::*; (
   input  dec_type         dec,
   input  logic [XLEN-1:0] pc,
   input  logic [XLEN-1:0] rs1_value,
   input  logic [XLEN-1:0] rs2_value,
   output rsp_type         rsp
);

   logic [XLEN-1:0]         op_b;
   logic [$clog2(XLEN)-1:0] shamt;
   logic [XLEN-1:0]         alu_res;
   logic [XLEN-1:0]         pc_sum;
   logic [XLEN-1:0]         rs1_sum;
   logic                    lt_s;
   logic                    lt_u;
   logic                    eq;

   // shared operand selection and compares
   always_comb begin
      op_b    = dec.use_imm ? dec.imm : rs2_value;
      shamt   = op_b[$clog2(XLEN)-1:0];
      pc_sum  = pc + dec.imm;
      rs1_sum = rs1_value + dec.imm;
      lt_s    = $signed(rs1_value) < $signed(op_b);
      lt_u    = rs1_value < op_b;
      eq      = rs1_value == op_b;
   end

   // alu
   always_comb begin
      case (dec.alu_op)
         ALU_ADD:  alu_res = rs1_value + op_b;
         ALU_SUB:  alu_res = rs1_value - op_b;
         ALU_SLL:  alu_res = rs1_value << shamt;
         ALU_SLT:  alu_res = {{(XLEN-1){1'b0}}, lt_s};
         ALU_SLTU: alu_res = {{(XLEN-1){1'b0}}, lt_u};
         ALU_XOR:  alu_res = rs1_value ^ op_b;
         ALU_SRL:  alu_res = rs1_value >> shamt;
         ALU_SRA:  alu_res = XLEN'($signed(rs1_value) >>> shamt);
         ALU_OR:   alu_res = rs1_value | op_b;
         ALU_AND:  alu_res = rs1_value & op_b;
         default:  alu_res = '0;
      endcase
   end

   // result packing
   always_comb begin
      rsp               = '0;
      rsp.illegal       = dec.illegal;
      rsp.kind          = dec.kind;
      rsp.writes_rd     = dec.writes_rd;
      rsp.rd_index      = dec.writes_rd ? dec.rd_index : 5'd0;
      rsp.access_size   = dec.access_size;
      rsp.load_unsigned = dec.load_unsigned;
      rsp.store_data    = dec.store_en ? rs2_value : '0;

      case (dec.res_sel)
         RES_ALU:   rsp.result_value = alu_res;
         RES_UIMM:  rsp.result_value = dec.imm;
         RES_AUIPC: rsp.result_value = pc_sum;
         RES_LINK:  rsp.result_value = pc + XLEN'(4);
         default:   rsp.result_value = '0;
      endcase

      case (dec.tgt_sel)
         TGT_PC_IMM:  rsp.target_or_address = pc_sum;
         TGT_RS1_IMM: rsp.target_or_address = rs1_sum;
         TGT_JALR:    rsp.target_or_address = {rs1_sum[XLEN-1:1], 1'b0};
         default:     rsp.target_or_address = '0;
      endcase

      case (dec.br_cond)
         BR_ALWAYS: rsp.taken = 1'b1;
         BR_EQ:     rsp.taken = eq;
         BR_NE:     rsp.taken = !eq;
         BR_LT:     rsp.taken = lt_s;
         BR_GE:     rsp.taken = !lt_s;
         BR_LTU:    rsp.taken = lt_u;
         BR_GEU:    rsp.taken = !lt_u;
         default:   rsp.taken = 1'b0;
      endcase
   end

endmodule
